// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with async active-low reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

// File: rtl/adgu_pkg.sv
package adgu_pkg;

	localparam int ENTRIES_DEF = 4096;

	localparam int IDX_W  = 12;
	localparam int W_W    = 32;
	localparam int LR_W   = 24;
	localparam int EPS_W  = 32;
	localparam int ACC_W  = 48;
	localparam int SQ_W   = 40;
	localparam int RAD_W  = 72;
	localparam int ROOT_W = 36;
	localparam int D_W    = 37;
	localparam int NUM_W  = 56;
	localparam int STEPS  = 4;

	localparam logic [EPS_W-1:0] EPS_RESET = 32'd167772;
	localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ACC_OVF = 2'd1,
		ST_W_SAT   = 2'd2
	} status_t;

	// sideband through the root pipe
	typedef struct packed {
		logic [W_W-1:0]   w;
		logic             g_neg;
		status_t          st;
		logic [NUM_W-1:0] num;
	} root_side_t;

	// sideband through the divider
	typedef struct packed {
		logic [W_W-1:0] w;
		logic           g_neg;
		status_t        st;
		logic           dz;
	} div_side_t;

endpackage

// File: rtl/adgu_ram.sv
module adgu_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/adgu_sqrt.sv
module adgu_sqrt #(
	parameter int RAD_W = 72,
	parameter int SIDE_W = 1,
	parameter int STEPS = 4,
	localparam int ROOT_W = RAD_W / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int REM_W = ROOT_W + 2;
	localparam int NSTG = (ROOT_W + STEPS - 1) / STEPS;

	logic [NSTG-1:0]   vld_s;
	logic [REM_W-1:0]  rem_s  [NSTG];
	logic [ROOT_W-1:0] root_s [NSTG];
	logic [RAD_W-1:0]  rad_s  [NSTG];
	logic [SIDE_W-1:0] side_s [NSTG];

	logic [REM_W-1:0]  rem_c  [NSTG];
	logic [ROOT_W-1:0] root_c [NSTG];
	logic [RAD_W-1:0]  rad_c  [NSTG];
	logic [SIDE_W-1:0] side_c [NSTG];

	logic [REM_W-1:0]  rem_n  [NSTG];
	logic [ROOT_W-1:0] root_n [NSTG];
	logic [RAD_W-1:0]  rad_n  [NSTG];

	for (genvar s = 0; s < NSTG; s++) begin : g_stg
		if (s == 0) begin : g_first
			assign rem_c[s]  = '0;
			assign root_c[s] = '0;
			assign rad_c[s]  = in_rad;
			assign side_c[s] = in_side;
		end else begin : g_next
			assign rem_c[s]  = rem_s[s-1];
			assign root_c[s] = root_s[s-1];
			assign rad_c[s]  = rad_s[s-1];
			assign side_c[s] = side_s[s-1];
		end

		// STEPS digit pairs of the restoring root per stage
		always_comb begin : step
			logic [REM_W-1:0]  r;
			logic [ROOT_W-1:0] q;
			logic [RAD_W-1:0]  rd;
			logic [REM_W-1:0]  trial;
			r  = rem_c[s];
			q  = root_c[s];
			rd = rad_c[s];
			for (int t = 0; t < STEPS; t++) begin
				if (s * STEPS + t < ROOT_W) begin
					r     = {r[REM_W-3:0], rd[RAD_W-1 -: 2]};
					rd    = {rd[RAD_W-3:0], 2'b00};
					trial = {q, 2'b01};
					if (r >= trial) begin
						r = r - trial;
						q = {q[ROOT_W-2:0], 1'b1};
					end else begin
						q = {q[ROOT_W-2:0], 1'b0};
					end
				end
			end
			rem_n[s]  = r;
			root_n[s] = q;
			rad_n[s]  = rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int s = 1; s < NSTG; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NSTG; s++) begin
				rem_s[s]  <= rem_n[s];
				root_s[s] <= root_n[s];
				rad_s[s]  <= rad_n[s];
				side_s[s] <= side_c[s];
			end
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign out_root = root_s[NSTG-1];
	assign out_side = side_s[NSTG-1];

endmodule

// File: rtl/adgu_div.sv
module adgu_div #(
	parameter int N_W = 56,
	parameter int D_W = 37,
	parameter int SIDE_W = 1,
	parameter int STEPS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [N_W-1:0]    in_num,
	input  logic [D_W-1:0]    in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [N_W-1:0]    out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NSTG = (N_W + STEPS - 1) / STEPS;

	logic [NSTG-1:0]   vld_s;
	logic [D_W-1:0]    rem_s  [NSTG];
	logic [N_W-1:0]    num_s  [NSTG];
	logic [N_W-1:0]    quo_s  [NSTG];
	logic [D_W-1:0]    den_s  [NSTG];
	logic [SIDE_W-1:0] side_s [NSTG];

	logic [D_W-1:0]    rem_c  [NSTG];
	logic [N_W-1:0]    num_c  [NSTG];
	logic [N_W-1:0]    quo_c  [NSTG];
	logic [D_W-1:0]    den_c  [NSTG];
	logic [SIDE_W-1:0] side_c [NSTG];

	logic [D_W-1:0] rem_n [NSTG];
	logic [N_W-1:0] num_n [NSTG];
	logic [N_W-1:0] quo_n [NSTG];

	for (genvar s = 0; s < NSTG; s++) begin : g_stg
		if (s == 0) begin : g_first
			assign rem_c[s]  = '0;
			assign num_c[s]  = in_num;
			assign quo_c[s]  = '0;
			assign den_c[s]  = in_den;
			assign side_c[s] = in_side;
		end else begin : g_next
			assign rem_c[s]  = rem_s[s-1];
			assign num_c[s]  = num_s[s-1];
			assign quo_c[s]  = quo_s[s-1];
			assign den_c[s]  = den_s[s-1];
			assign side_c[s] = side_s[s-1];
		end

		// restoring division, STEPS quotient bits per stage
		always_comb begin : step
			logic [D_W:0]   r;
			logic [N_W-1:0] n;
			logic [N_W-1:0] q;
			r = {1'b0, rem_c[s]};
			n = num_c[s];
			q = quo_c[s];
			for (int t = 0; t < STEPS; t++) begin
				if (s * STEPS + t < N_W) begin
					r = {r[D_W-1:0], n[N_W-1]};
					n = {n[N_W-2:0], 1'b0};
					if (r >= {1'b0, den_c[s]}) begin
						r = r - {1'b0, den_c[s]};
						q = {q[N_W-2:0], 1'b1};
					end else begin
						q = {q[N_W-2:0], 1'b0};
					end
				end
			end
			rem_n[s] = r[D_W-1:0];
			num_n[s] = n;
			quo_n[s] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int s = 1; s < NSTG; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NSTG; s++) begin
				rem_s[s]  <= rem_n[s];
				num_s[s]  <= num_n[s];
				quo_s[s]  <= quo_n[s];
				den_s[s]  <= den_c[s];
				side_s[s] <= side_c[s];
			end
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign out_quo  = quo_s[NSTG-1];
	assign out_side = side_s[NSTG-1];

endmodule

// File: rtl/adagrad_parameter_update.sv
// AdaGrad update engine: one item per clock while not stalled, through a
// pipeline of square and accumulator read (stage 1), accumulator update
// (stage 2), the 36-bit square root at 4 digits per stage, denominator
// build, the 56-bit quotient at 4 bits per stage and an output register.
// The whole pipeline advances together and freezes while result_stall holds a
// waiting result. After reset the accumulator RAM is cleared entry by entry over
// all ENTRIES entries (4096 by default); items are stalled during it, epsilon
// writes are always taken. Back-to-back items to the same entry are handled
// by forwarding the freshly written accumulator.
`include "assert_macros.svh"

module adagrad_parameter_update #(
	parameter int ENTRIES = adgu_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// epsilon write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [adgu_pkg::EPS_W-1:0] epsilon,
	// item channel
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [adgu_pkg::IDX_W-1:0] entry_index,
	input  logic [adgu_pkg::W_W-1:0]   weight,
	input  logic [adgu_pkg::W_W-1:0]   gradient,
	input  logic [adgu_pkg::LR_W-1:0]  step_rate,
	input  logic                       restart,
	// result channel
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [adgu_pkg::W_W-1:0]   new_weight,
	output logic [1:0]                 status
);

	import adgu_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// ---------------- config ----------------
	logic [EPS_W-1:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid) begin
			eps_q <= epsilon;
		end
	end

	// ---------------- clear pass ----------------
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (32'(clr_cnt_q) == ENTRIES - 1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- handshake ----------------
	logic en;
	logic item_acc;

	// whole pipe moves unless a finished result is held
	assign en         = !result_valid || !result_stall;
	assign item_stall = clearing_q || !en;
	assign item_acc   = item_valid && !item_stall;

	// ---------------- stage 1: square, read ----------------
	logic [W_W-1:0]  mag_in;
	logic [63:0]     msq_in;
	logic            inr_in;

	assign mag_in = gradient[W_W-1] ? (~gradient + 1'b1) : gradient;
	assign msq_in = 64'(mag_in) * 64'(mag_in);
	assign inr_in = 32'(entry_index) < ENTRIES;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inr_s1;
	logic             rst_s1;
	logic [SQ_W-1:0]  sq_s1;
	logic [W_W-1:0]   mag_s1;
	logic [LR_W-1:0]  lr_s1;
	logic [W_W-1:0]   w_s1;
	logic             gneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= entry_index;
			inr_s1  <= inr_in;
			rst_s1  <= restart;
			// Q16.48 to Q16.24, round half up
			sq_s1   <= SQ_W'((msq_in + 64'd8388608) >> 24);
			mag_s1  <= mag_in;
			lr_s1   <= step_rate;
			w_s1    <= weight;
			gneg_s1 <= gradient[W_W-1];
		end
	end

	// ---------------- accumulator RAM ----------------
	logic [ACC_W-1:0] ram_rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ACC_W-1:0] ram_wdata;
	logic [ACC_W-1:0] acc_n;

	assign ram_we    = clearing_q || (vld_s1 && inr_s1 && en);
	assign ram_waddr = clearing_q ? clr_cnt_q : AW'(idx_s1);
	assign ram_wdata = clearing_q ? '0 : acc_n;

	adgu_ram #(
		.W     (ACC_W),
		.DEPTH (ENTRIES)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (item_acc),
		.raddr (AW'(entry_index)),
		.rdata (ram_rdata)
	);

	// ---------------- stage 2: accumulate, write back ----------------
	logic             vld_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             inr_s2;
	logic [ACC_W-1:0] acc_s2;
	status_t          st_s2;
	logic [NUM_W-1:0] num_s2;
	logic [W_W-1:0]   w_s2;
	logic             gneg_s2;

	logic             fwd;
	logic [ACC_W-1:0] base;
	logic [ACC_W:0]   sum_acc;
	status_t          st_n;

	// previous item wrote this entry at the edge this item read it
	assign fwd = vld_s2 && inr_s2 && (idx_s2 == idx_s1);

	always_comb begin
		if (rst_s1 || !inr_s1) begin
			base = '0;
		end else if (fwd) begin
			base = acc_s2;
		end else begin
			base = ram_rdata;
		end
		sum_acc = {1'b0, base} + (ACC_W+1)'(sq_s1);
		if (sum_acc[ACC_W]) begin
			acc_n = ACC_MAX;
			st_n  = ST_ACC_OVF;
		end else begin
			acc_n = sum_acc[ACC_W-1:0];
			st_n  = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2  <= idx_s1;
			inr_s2  <= inr_s1;
			acc_s2  <= acc_n;
			st_s2   <= st_n;
			num_s2  <= NUM_W'(mag_s1) * NUM_W'(lr_s1);
			w_s2    <= w_s1;
			gneg_s2 <= gneg_s1;
		end
	end

	// ---------------- root pipe ----------------
	root_side_t        rside_in;
	root_side_t        rside_out;
	logic              vld_r;
	logic [ROOT_W-1:0] root_r;

	assign rside_in = '{w: w_s2, g_neg: gneg_s2, st: st_s2, num: num_s2};

	adgu_sqrt #(
		.RAD_W  (RAD_W),
		.SIDE_W ($bits(root_side_t)),
		.STEPS  (STEPS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_rad   ({acc_s2, 24'd0}),
		.in_side  (rside_in),
		.out_vld  (vld_r),
		.out_root (root_r),
		.out_side (rside_out)
	);

	// ---------------- stage 3: denominator, rounded dividend ----------------
	logic             vld_s3;
	logic [NUM_W-1:0] dvd_s3;
	logic [D_W-1:0]   den_s3;
	div_side_t        dside_s3;
	logic [D_W-1:0]   den_n;

	assign den_n = {1'b0, root_r} + D_W'(eps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3   <= den_n;
			// add half the divisor for round to nearest
			dvd_s3   <= rside_out.num + NUM_W'(den_n[D_W-1:1]);
			dside_s3 <= '{w: rside_out.w, g_neg: rside_out.g_neg, st: rside_out.st,
				dz: (den_n == '0)};
		end
	end

	// ---------------- divider ----------------
	logic             vld_d;
	logic [NUM_W-1:0] quo_d;
	div_side_t        dside_d;

	adgu_div #(
		.N_W    (NUM_W),
		.D_W    (D_W),
		.SIDE_W ($bits(div_side_t)),
		.STEPS  (STEPS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_num   (dvd_s3),
		.in_den   (den_s3),
		.in_side  (dside_s3),
		.out_vld  (vld_d),
		.out_quo  (quo_d),
		.out_side (dside_d)
	);

	// ---------------- output: apply, saturate ----------------
	localparam int WIDE_W = NUM_W + 2;

	logic signed [WIDE_W-1:0] w_wide;
	logic signed [WIDE_W-1:0] q_wide;
	logic signed [WIDE_W-1:0] nw_wide;
	logic                     w_ovf;
	logic [W_W-1:0]           nw_n;
	status_t                  st_out_n;

	assign w_wide  = WIDE_W'($signed(dside_d.w));
	assign q_wide  = $signed({2'b00, quo_d});
	assign nw_wide = dside_d.g_neg ? (w_wide + q_wide) : (w_wide - q_wide);
	assign w_ovf   = nw_wide[WIDE_W-1:W_W-1] != {(WIDE_W-W_W+1){nw_wide[W_W-1]}};

	always_comb begin
		if (dside_d.st != ST_OK || dside_d.dz) begin
			// overflowed accumulator or zero denominator: weight passes through
			nw_n     = dside_d.w;
			st_out_n = dside_d.st;
		end else if (w_ovf) begin
			nw_n     = nw_wide[WIDE_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
			st_out_n = ST_W_SAT;
		end else begin
			nw_n     = nw_wide[W_W-1:0];
			st_out_n = ST_OK;
		end
	end

	logic           vld_q;
	logic [W_W-1:0] nw_q;
	logic [W_W-1:0] w_q;
	status_t        st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nw_q <= nw_n;
			w_q  <= dside_d.w;
			st_q <= st_out_n;
		end
	end

	assign result_valid = vld_q;
	assign new_weight   = nw_q;
	assign status       = st_q;

	// ---------------- checks ----------------
	`ASSERT_NEVER(a_no_item_in_clear, clk, arst_n, clearing_q && vld_s1, "item in pipe during clear")
	`ASSERT_NEVER(a_status_code, clk, arst_n, vld_q && (st_q == 2'd3), "bad status code")
	`ASSERT_CLK(a_ovf_passthru, clk, arst_n, (vld_q && st_q == ST_ACC_OVF) |-> (nw_q == w_q), "overflow did not pass weight")

endmodule
